>>> hdl/crs3_pkg.sv
package crs3_pkg;

	localparam int CoefWidth = 16;
	localparam int FracBits = 16;
	localparam int OutBits = 48;
	localparam int ProdWidth = 2 * CoefWidth + 1;
	localparam int DetWidth = 3 * CoefWidth + 3;
	localparam int MagWidth = DetWidth;
	localparam int DivSteps = MagWidth + FracBits;
	localparam int StepWidth = $clog2(DivSteps + 1);
	localparam int QuoWidth = OutBits + 1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MINOR,
		ST_DET_D,
		ST_DET_X,
		ST_DET_Y,
		ST_DET_Z,
		ST_CHECK,
		ST_DIV_START,
		ST_DIV_RUN,
		ST_DIV_STORE,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		SEL_D,
		SEL_X,
		SEL_Y,
		SEL_Z
	} det_sel_t;

	typedef struct packed {
		logic       load_row;
		logic [1:0] row_idx;
		logic       minor_go;
		logic       det_go;
		det_sel_t   det_sel;
		logic       div_start;
		logic       div_step;
		logic       div_store;
		det_sel_t   div_sel;
		logic       set_singular;
	} dp_cmd_t;

	typedef struct packed {
		logic det_zero;
		logic div_done;
	} dp_stat_t;

endpackage

>>> hdl/crs3_datapath.sv
module crs3_datapath
	import crs3_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  dp_cmd_t                     cmd,
	output dp_stat_t                    stat,
	input  logic signed [CoefWidth-1:0] coef_x,
	input  logic signed [CoefWidth-1:0] coef_y,
	input  logic signed [CoefWidth-1:0] coef_z,
	input  logic signed [CoefWidth-1:0] rhs,
	output logic signed [OutBits-1:0]   x_value,
	output logic signed [OutBits-1:0]   y_value,
	output logic signed [OutBits-1:0]   z_value,
	output logic                        singular
);

	logic signed [CoefWidth-1:0] row_q [3][4];
	logic signed [ProdWidth-1:0] minor_q [4][3];
	logic signed [DetWidth-1:0]  det_q [4];
	logic signed [CoefWidth-1:0] ma [4][3];
	logic signed [CoefWidth-1:0] mb [4][3];
	logic signed [CoefWidth-1:0] mc [4][3];
	logic signed [DetWidth-1:0]  det_sum;
	logic [MagWidth-1:0]         num_mag_q;
	logic [MagWidth-1:0]         den_mag_q;
	logic [MagWidth:0]           rem_q;
	logic [QuoWidth-1:0]         quo_q;
	logic                        neg_q;
	logic                        sat_q;
	logic [StepWidth-1:0]        step_q;
	logic [MagWidth:0]           rem_shift;
	logic [QuoWidth-1:0]         quo_next;
	logic                        num_bit;
	logic signed [DetWidth-1:0]  num_sel;
	logic signed [DetWidth-1:0]  den;
	logic [OutBits-1:0]          result;
	logic [QuoWidth-1:0]         lim;

	function automatic logic [MagWidth-1:0] mag_of(input logic signed [DetWidth-1:0] v);
		logic [DetWidth-1:0] n;
		begin
			n = v[DetWidth-1] ? -v : v;
			return n;
		end
	endfunction

	always_ff @(posedge clk) begin
		if (cmd.load_row) begin
			row_q[cmd.row_idx][0] <= coef_x;
			row_q[cmd.row_idx][1] <= coef_y;
			row_q[cmd.row_idx][2] <= coef_z;
			row_q[cmd.row_idx][3] <= rhs;
		end
	end

	always_comb begin
		for (int s = 0; s < 4; s++) begin
			for (int c = 0; c < 3; c++) begin
				ma[s][c] = row_q[0][c];
				mb[s][c] = row_q[1][c];
				mc[s][c] = row_q[2][c];
			end
			if (s > 0) begin
				ma[s][s-1] = row_q[0][3];
				mb[s][s-1] = row_q[1][3];
				mc[s][s-1] = row_q[2][3];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.minor_go) begin
			for (int s = 0; s < 4; s++) begin
				minor_q[s][0] <= ProdWidth'(mb[s][1] * mc[s][2]) - ProdWidth'(mb[s][2] * mc[s][1]);
				minor_q[s][1] <= ProdWidth'(mb[s][0] * mc[s][2]) - ProdWidth'(mb[s][2] * mc[s][0]);
				minor_q[s][2] <= ProdWidth'(mb[s][0] * mc[s][1]) - ProdWidth'(mb[s][1] * mc[s][0]);
			end
		end
	end

	always_comb begin
		det_sum = DetWidth'(ma[cmd.det_sel][0] * minor_q[cmd.det_sel][0])
			- DetWidth'(ma[cmd.det_sel][1] * minor_q[cmd.det_sel][1])
			+ DetWidth'(ma[cmd.det_sel][2] * minor_q[cmd.det_sel][2]);
	end

	always_ff @(posedge clk) begin
		if (cmd.det_go) begin
			det_q[cmd.det_sel] <= det_sum;
		end
	end

	assign den = det_q[SEL_D];
	assign num_sel = det_q[cmd.div_sel];
	assign stat.det_zero = (den == '0);
	assign lim = QuoWidth'(1) << (OutBits - 1);

	always_comb begin
		num_bit = 1'b0;
		if (step_q >= StepWidth'(FracBits + 1)) begin
			num_bit = num_mag_q[MagWidth-1];
		end
		rem_shift = {rem_q[MagWidth-1:0], num_bit};
		quo_next = {quo_q[QuoWidth-2:0], 1'b0};
		if (rem_shift >= {1'b0, den_mag_q}) begin
			quo_next[0] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (cmd.div_start) begin
			step_q <= StepWidth'(DivSteps);
		end else if (cmd.div_step && step_q != '0) begin
			step_q <= step_q - 1'b1;
		end
	end

	assign stat.div_done = (step_q == '0);

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			num_mag_q <= mag_of(num_sel);
			den_mag_q <= mag_of(den);
			neg_q <= num_sel[DetWidth-1] ^ den[DetWidth-1];
			rem_q <= '0;
			quo_q <= '0;
			sat_q <= 1'b0;
		end else if (cmd.div_step && step_q != '0) begin
			if (step_q >= StepWidth'(FracBits + 1)) begin
				num_mag_q <= {num_mag_q[MagWidth-2:0], 1'b0};
			end
			if (rem_shift >= {1'b0, den_mag_q}) begin
				rem_q <= rem_shift - {1'b0, den_mag_q};
			end else begin
				rem_q <= rem_shift;
			end
			if (!sat_q) begin
				if (quo_next > lim) begin
					sat_q <= 1'b1;
				end else begin
					quo_q <= quo_next;
				end
			end
		end
	end

	always_comb begin
		if (neg_q) begin
			result = sat_q ? OutBits'(-lim) : OutBits'(-quo_q);
		end else if (sat_q || quo_q == lim) begin
			result = OutBits'(lim - 1'b1);
		end else begin
			result = OutBits'(quo_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.set_singular) begin
			x_value <= '0;
			y_value <= '0;
			z_value <= '0;
			singular <= 1'b1;
		end else if (cmd.div_store) begin
			singular <= 1'b0;
			case (cmd.div_sel)
				SEL_X: x_value <= result;
				SEL_Y: y_value <= result;
				SEL_Z: z_value <= result;
				default: x_value <= result;
			endcase
		end
	end

	property p_quo_bound;
		@(posedge clk) disable iff (!arst_n) cmd.div_store |-> quo_q <= lim;
	endproperty
	a_quo_bound: assert property (p_quo_bound) else $error("quotient beyond limit");

	property p_store_done;
		@(posedge clk) disable iff (!arst_n) cmd.div_store |-> stat.div_done;
	endproperty
	a_store_done: assert property (p_store_done) else $error("store before divide done");

	property p_start_count;
		@(posedge clk) disable iff (!arst_n) cmd.div_start |=> step_q == StepWidth'(DivSteps);
	endproperty
	a_start_count: assert property (p_start_count) else $error("divide count not loaded");

endmodule

>>> hdl/crs3_ctrl.sv
module crs3_ctrl
	import crs3_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	output dp_cmd_t  cmd,
	input  dp_stat_t stat
);

	state_t     state_q, state_d;
	logic [1:0] count_q, count_d;
	det_sel_t   sel_q, sel_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			sel_q <= SEL_X;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			sel_q <= sel_d;
		end
	end

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		sel_d = sel_q;
		cmd = '0;
		cmd.det_sel = SEL_D;
		cmd.div_sel = sel_q;
		cmd.row_idx = count_q;
		in_stall = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load_row = 1'b1;
					if (count_q == 2'd2) begin
						count_d = '0;
						state_d = ST_MINOR;
					end else begin
						count_d = count_q + 1'b1;
					end
				end
			end
			ST_MINOR: begin
				cmd.minor_go = 1'b1;
				state_d = ST_DET_D;
			end
			ST_DET_D: begin
				cmd.det_go = 1'b1;
				cmd.det_sel = SEL_D;
				state_d = ST_DET_X;
			end
			ST_DET_X: begin
				cmd.det_go = 1'b1;
				cmd.det_sel = SEL_X;
				state_d = ST_DET_Y;
			end
			ST_DET_Y: begin
				cmd.det_go = 1'b1;
				cmd.det_sel = SEL_Y;
				state_d = ST_DET_Z;
			end
			ST_DET_Z: begin
				cmd.det_go = 1'b1;
				cmd.det_sel = SEL_Z;
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				sel_d = SEL_X;
				if (stat.det_zero) begin
					cmd.set_singular = 1'b1;
					state_d = ST_OUT;
				end else begin
					state_d = ST_DIV_START;
				end
			end
			ST_DIV_START: begin
				cmd.div_start = 1'b1;
				state_d = ST_DIV_RUN;
			end
			ST_DIV_RUN: begin
				cmd.div_step = 1'b1;
				if (stat.div_done) begin
					state_d = ST_DIV_STORE;
				end
			end
			ST_DIV_STORE: begin
				cmd.div_store = 1'b1;
				if (sel_q == SEL_Z) begin
					state_d = ST_OUT;
				end else begin
					sel_d = det_sel_t'(sel_q + 1'b1);
					state_d = ST_DIV_START;
				end
			end
			ST_OUT: begin
				out_valid = 1'b1;
				in_stall = (count_q == 2'd2);
				if (in_valid && count_q != 2'd2) begin
					cmd.load_row = 1'b1;
					count_d = count_q + 1'b1;
				end
				if (!out_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	property p_no_in_busy;
		@(posedge clk) disable iff (!arst_n)
			(state_q != ST_IDLE && state_q != ST_OUT) |-> in_stall;
	endproperty
	a_no_in_busy: assert property (p_no_in_busy) else $error("input open while busy");

	property p_count_range;
		@(posedge clk) disable iff (!arst_n) count_q != 2'd3;
	endproperty
	a_count_range: assert property (p_count_range) else $error("row count out of range");

	property p_third_row;
		@(posedge clk) disable iff (!arst_n)
			(in_valid && !in_stall && count_q == 2'd2) |=> state_q == ST_MINOR;
	endproperty
	a_third_row: assert property (p_third_row) else $error("third row did not start solve");

endmodule

>>> hdl/cramer_solver_3x3_core.sv
// Channel  | Handshake            | Payload
// input    | in_valid, in_stall   | coef_x, coef_y, coef_z, rhs
// output   | out_valid, out_stall | x_value, y_value, z_value, singular
// Rows one and two are taken without stalling the input.
// After the third row, the minors and the four determinants are formed, and the result is set by the
// shared bit-serial divider that runs once for each of x, y and z.
// A singular system skips the divider.
// Reset clears the row count and the controller; stored rows are not cleared.
// While a result is stalled, rows one and two of the next system can transfer,
// but the third row waits.
module cramer_solver_3x3_core
	import crs3_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic signed [CoefWidth-1:0] coef_x,
	input  logic signed [CoefWidth-1:0] coef_y,
	input  logic signed [CoefWidth-1:0] coef_z,
	input  logic signed [CoefWidth-1:0] rhs,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [OutBits-1:0]   x_value,
	output logic signed [OutBits-1:0]   y_value,
	output logic signed [OutBits-1:0]   z_value,
	output logic                        singular
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	crs3_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	crs3_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.coef_x   (coef_x),
		.coef_y   (coef_y),
		.coef_z   (coef_z),
		.rhs      (rhs),
		.x_value  (x_value),
		.y_value  (y_value),
		.z_value  (z_value),
		.singular (singular)
	);

endmodule

>>> dv/tb_cramer_solver_3x3_core.sv
module tb_cramer_solver_3x3_core;
	import crs3_pkg::*;

	typedef struct {
		logic signed [OutBits-1:0] x;
		logic signed [OutBits-1:0] y;
		logic signed [OutBits-1:0] z;
		logic                      sing;
	} solution_t;

	logic                        clk;
	logic                        arst_n;
	logic                        in_valid;
	logic                        in_stall;
	logic signed [CoefWidth-1:0] coef_x;
	logic signed [CoefWidth-1:0] coef_y;
	logic signed [CoefWidth-1:0] coef_z;
	logic signed [CoefWidth-1:0] rhs;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic signed [OutBits-1:0]   x_value;
	logic signed [OutBits-1:0]   y_value;
	logic signed [OutBits-1:0]   z_value;
	logic                        singular;

	solution_t   pending_solutions[$];
	longint      stored_rows[2][4];
	int          rows_taken;
	int          mismatches = 0;
	longint      cycles = 0;
	int          burst_left;
	int          gap_max;
	int          stall_pct = 30;
	int          hold_req;
	int          hold_seen = 0;
	int          hold_left = 0;

	cramer_solver_3x3_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.coef_x    (coef_x),
		.coef_y    (coef_y),
		.coef_z    (coef_z),
		.rhs       (rhs),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.x_value   (x_value),
		.y_value   (y_value),
		.z_value   (z_value),
		.singular  (singular)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic longint det3(longint a, longint b, longint c, longint d, longint e,
			longint f, longint g, longint h, longint i);
		return a * (e * i - f * h) - b * (d * i - f * g) + c * (d * h - e * g);
	endfunction

	function automatic logic [OutBits-1:0] scaled_quotient(longint n, longint d);
		logic [127:0] un;
		logic [127:0] ud;
		logic [127:0] q;
		logic [127:0] lim;
		bit           neg;
		un = 128'(n < 0 ? -n : n);
		ud = 128'(d < 0 ? -d : d);
		neg = (n < 0) != (d < 0);
		lim = 128'(1) << (OutBits - 1);
		q = (un << FracBits) / ud;
		if (neg) begin
			if (q > lim)
				q = lim;
			q = ~q + 128'(1);
		end else if (q >= lim) begin
			q = lim - 128'(1);
		end
		return q[OutBits-1:0];
	endfunction

	task automatic solve_system(longint a, longint b, longint c, longint d);
		solution_t s;
		longint    dd;
		longint    dx;
		longint    dy;
		longint    dz;
		dd = det3(stored_rows[0][0], stored_rows[0][1], stored_rows[0][2],
			stored_rows[1][0], stored_rows[1][1], stored_rows[1][2], a, b, c);
		dx = det3(stored_rows[0][3], stored_rows[0][1], stored_rows[0][2],
			stored_rows[1][3], stored_rows[1][1], stored_rows[1][2], d, b, c);
		dy = det3(stored_rows[0][0], stored_rows[0][3], stored_rows[0][2],
			stored_rows[1][0], stored_rows[1][3], stored_rows[1][2], a, d, c);
		dz = det3(stored_rows[0][0], stored_rows[0][1], stored_rows[0][3],
			stored_rows[1][0], stored_rows[1][1], stored_rows[1][3], a, b, d);
		if (dd == 0) begin
			s.x = '0;
			s.y = '0;
			s.z = '0;
			s.sing = 1'b1;
		end else begin
			s.x = scaled_quotient(dx, dd);
			s.y = scaled_quotient(dy, dd);
			s.z = scaled_quotient(dz, dd);
			s.sing = 1'b0;
		end
		pending_solutions.push_back(s);
	endtask

	task automatic send_row(int a, int b, int c, int d);
		int g;
		in_valid <= 1'b1;
		coef_x <= CoefWidth'(a);
		coef_y <= CoefWidth'(b);
		coef_z <= CoefWidth'(c);
		rhs <= CoefWidth'(d);
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (rows_taken < 2) begin
			stored_rows[rows_taken][0] = longint'(signed'(CoefWidth'(a)));
			stored_rows[rows_taken][1] = longint'(signed'(CoefWidth'(b)));
			stored_rows[rows_taken][2] = longint'(signed'(CoefWidth'(c)));
			stored_rows[rows_taken][3] = longint'(signed'(CoefWidth'(d)));
			rows_taken++;
		end else begin
			rows_taken = 0;
			solve_system(longint'(signed'(CoefWidth'(a))), longint'(signed'(CoefWidth'(b))),
				longint'(signed'(CoefWidth'(c))), longint'(signed'(CoefWidth'(d))));
		end
		if (burst_left > 0) begin
			burst_left--;
		end else if (gap_max > 0) begin
			g = $urandom_range(1, gap_max);
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
			burst_left = $urandom_range(0, 9);
		end
	endtask

	task automatic send_system(int m[3][4]);
		for (int r = 0; r < 3; r++)
			send_row(m[r][0], m[r][1], m[r][2], m[r][3]);
	endtask

	function automatic int rand_coef(int kind);
		case (kind)
			0: return $urandom_range(0, 65535) - 32768;
			1: return $urandom_range(0, 16) - 8;
			2: return $urandom_range(0, 1) ? 32767 : -32768;
			default: return $urandom_range(0, 512) - 256;
		endcase
	endfunction

	task automatic test_directed();
		send_system('{'{1, 0, 0, 5}, '{0, 1, 0, -7}, '{0, 0, 1, 32767}});
		send_system('{'{2, 1, -1, 8}, '{-3, -1, 2, -11}, '{-2, 1, 2, -3}});
		send_system('{'{0, 0, 0, 1}, '{1, 2, 3, 4}, '{5, 6, 7, 8}});
		send_system('{'{1, 2, 3, 4}, '{2, 4, 6, 8}, '{7, -1, 3, 0}});
		send_system('{'{1, -32768, 0, 32767}, '{0, 1, -32768, 32767}, '{0, 0, 1, 32767}});
		send_system('{'{1, -32768, 0, -32768}, '{0, 1, -32768, -32768}, '{0, 0, 1, -32768}});
		send_system('{'{-32768, 32767, -32768, 32767}, '{32767, -32768, 32767, -32768},
			'{-32768, -32768, 32767, 32767}});
		send_system('{'{32767, 0, 0, -32768}, '{0, -32768, 0, 32767}, '{0, 0, 3, 1}});
	endtask

	task automatic test_random(int systems);
		int m[3][4];
		int kind;
		int shape;
		for (int s = 0; s < systems; s++) begin
			if (s % 100 == 50) begin
				gap_max = 0;
				burst_left = 0;
			end else if (s % 100 == 70) begin
				gap_max = 12;
			end
			kind = $urandom_range(0, 3);
			shape = $urandom_range(0, 9);
			for (int r = 0; r < 3; r++)
				for (int k = 0; k < 4; k++)
					m[r][k] = rand_coef(kind);
			if (shape == 0)
				m[2] = m[$urandom_range(0, 1)];
			else if (shape == 1)
				for (int r = 0; r < 3; r++)
					m[r][$urandom_range(0, 2)] = 0;
			send_system(m);
		end
	endtask

	task automatic test_backpressure();
		int m[3][4];
		hold_req++;
		gap_max = 0;
		for (int s = 0; s < 6; s++) begin
			for (int r = 0; r < 3; r++)
				for (int k = 0; k < 4; k++)
					m[r][k] = rand_coef(3);
			send_system(m);
		end
		gap_max = 12;
	endtask

	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = 1500;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < stall_pct);
			if ($urandom_range(0, 299) == 0)
				stall_pct <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(10, 80);
		end
	end

	always @(posedge clk) begin
		solution_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_solutions.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transfer x=%0d y=%0d z=%0d singular=%0b",
						x_value, y_value, z_value, singular);
			end else begin
				e = pending_solutions.pop_front();
				if (x_value !== e.x || y_value !== e.y || z_value !== e.z
						|| singular !== e.sing) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected x=%0d y=%0d z=%0d s=%0b, got x=%0d y=%0d z=%0d s=%0b",
							e.x, e.y, e.z, e.sing, x_value, y_value, z_value, singular);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 3000000) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		coef_x = '0;
		coef_y = '0;
		coef_z = '0;
		rhs = '0;
		rows_taken = 0;
		burst_left = 0;
		gap_max = 12;
		hold_req = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random(400);
		in_valid <= 1'b0;
		while (pending_solutions.size() != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
		if (mismatches == 0 && pending_solutions.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

>>> filelist.f
hdl/crs3_pkg.sv
hdl/crs3_datapath.sv
hdl/crs3_ctrl.sv
hdl/cramer_solver_3x3_core.sv
dv/tb_cramer_solver_3x3_core.sv
